// File: hw/rtl/rsd_pkg.sv
// Package for the rotary speaker block: widths, fixed-point constants, sine ROM fill.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsd_pkg;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 24;
    localparam int RATE_W   = 16;
    localparam int SPREAD_W = 9;
    localparam int PSCALE_W = 16;

    localparam logic [15:0] HORN_FAST = 16'd25395;
    localparam logic [15:0] HORN_SLOW = 16'd3277;
    localparam logic [15:0] DRUM_FAST = 16'd22938;
    localparam logic [15:0] DRUM_SLOW = 16'd2744;
    localparam logic [13:0] HORN_GLIDE_K = 14'd15099;
    localparam logic [13:0] DRUM_GLIDE_K = 14'd11744;
    localparam logic [12:0] LP_COEF = 13'd4588;
    localparam logic [15:0] GAIN_BASE = 16'd27075;
    localparam logic [12:0] GAIN_HORN = 13'd4260;
    localparam logic [10:0] GAIN_DRUM = 11'd1434;

    typedef enum logic [1:0] {
        REG_SPEED  = 2'd0,
        REG_SPREAD = 2'd1,
        REG_PSCALE = 2'd2
    } t_reg_idx;

    // Round half away from zero of v / 2^sh on a 64-bit signed value.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int sh);
        logic signed [63:0] half;
        logic signed [63:0] a;
        half = 64'sd1 <<< (sh - 1);
        if (v >= 0) begin
            rshr = (v + half) >>> sh;
        end else begin
            a = -v;
            rshr = -((a + half) >>> sh);
        end
    endfunction

    // Quintic sine entry k of a table of depth d, Q1.15.
    function automatic logic signed [15:0] sine_entry(input int k, input int d);
        logic [63:0] q4;
        logic [1:0]  quad;
        logic signed [63:0] z, z2, inner, mid, s;
        q4 = 64'(k) * 64'd4;
        quad = 2'(q4 / 64'(d));
        z = 64'(((q4 % 64'(d)) << 16) / 64'(d));
        if (quad[0]) begin
            z = 64'sd65536 - z;
        end
        z2 = (z * z) >>> 16;
        inner = 64'sd84095 - ((z2 * 64'sd9279) >>> 16);
        mid = 64'sd205887 - ((z2 * inner) >>> 16);
        s = (z * mid) >>> 17;
        s = (s + 64'sd1) >>> 1;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        sine_entry = quad[1] ? 16'(-s) : 16'(s);
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/rsd_serial_mac.sv
// Shift-add multiplier: signed A times signed B, one bit of B per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module rsd_serial_mac #(
    parameter int AW = 24,
    parameter int BW = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic                      o_done,
    output logic signed [AW+BW-1:0]   o_prod
);
    localparam int CW = $clog2(BW + 1);
    logic signed [AW+BW-1:0] r_acc, r_a;
    logic [BW-1:0] r_b;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CW'(BW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_a    <= (AW+BW)'(i_a);
                r_b    <= i_b;
                r_cnt  <= '0;
            end else if (r_busy) begin
                // top bit of B carries negative weight
                if (r_b[0]) begin
                    if (r_cnt == CW'(BW - 1)) begin
                        r_acc <= r_acc - r_a;
                    end else begin
                        r_acc <= r_acc + r_a;
                    end
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// File: hw/rtl/rotary_speaker_doppler_am.sv
// Top level of the rotary speaker block: sequencer, state, ring, sine ROM.
// Depends on rsd_pkg and rsd_serial_mac.
`timescale 1ns / 1ps
`default_nettype none
// Rotary speaker stereo processor.
// Input channel: i_sample_in with i_in_valid / o_in_ready; one mono Q1.15
// sample per transaction. Output channel: o_left_out / o_right_out with
// o_out_valid / i_out_ready; one stereo pair per input transaction.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 speed_fast, 1 spread, 2 phase_scale. Write only while idle; a
// config transaction that is taken holds off the input for that cycle.
// Each sample runs through a sequencer that issues 23 products on one shared
// bit-serial multiplier, one multiplier bit per cycle. Each of the four ring
// reads adds a setup state (S_TAP) before its product is issued. The next
// sample is accepted only once the sequencer has handed the previous pair on
// and returned to idle, so one sample is in the sequencer at a time.
// The result sits in an output register; the next sample is accepted while
// the previous result still waits, and work on it proceeds. If the new result
// is ready before the old one is taken, the sequencer holds until it is.
// Synchronous active-low reset clears rotor state, lowpass, write slot and
// registers; the ring resets to zeros through per-entry valid bits.
module rotary_speaker_doppler_am #(
    parameter int DELAY_DEPTH      = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [rsd_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [rsd_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [rsd_pkg::SAMPLE_W-1:0] o_right_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import rsd_pkg::*;

    localparam int DI  = $clog2(DELAY_DEPTH);
    localparam int SI  = $clog2(SINE_TABLE_DEPTH);
    localparam int PW  = DI + 12;   // ring position in Q.12

    localparam int MW = 24;
    typedef enum logic [4:0] {
        S_IDLE, S_GH, S_GD, S_PH, S_PD, S_LP, S_SP, S_MODH, S_MODD,
        S_TAP, S_TAPW, S_CH, S_CD, S_DOP, S_DOPW, S_GAIN, S_HOLD
    } t_state;

    t_state r_state;
    logic [1:0] r_tap;       // 0 horn+, 1 drum+, 2 horn-, 3 drum-
    logic       r_sub;       // sub-step within a product pair

    logic        r_speed;
    logic [8:0]  r_spread;
    logic [15:0] r_pscale;
    logic [15:0] r_hrate, r_drate;
    logic [23:0] r_hph, r_dph;
    logic signed [16:0] r_lp;
    logic signed [16:0] r_x, r_high;
    logic [DI-1:0] r_wslot;
    logic signed [SAMPLE_W-1:0] r_ring [DELAY_DEPTH];
    logic [DELAY_DEPTH-1:0] r_rvalid;
    logic signed [16:0] r_modh, r_modd;
    logic signed [17:0] r_tapv [4];
    logic signed [17:0] r_gl, r_gr;
    logic signed [47:0] r_dacc;
    logic signed [17:0] r_dopl;
    logic [2:0]  r_pend;      // spread-scaling step
    logic [15:0] r_bh, r_bd, r_dh, r_dd;
    logic signed [15:0] r_sh, r_sd;

    // shared multiplier
    logic                 m_start, m_done, n_start;
    logic signed [MW-1:0] m_a, m_b;
    logic signed [2*MW-1:0] m_p;
    logic signed [63:0]   m_p64;
    rsd_serial_mac #(.AW(MW), .BW(MW)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m_a), .i_b(m_b), .o_done(m_done), .o_prod(m_p)
    );
    assign m_p64 = 64'(m_p);

    // constant sine table, filled at elaboration
    logic signed [15:0] c_sine [SINE_TABLE_DEPTH];
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        assign c_sine[g] = sine_entry(g, SINE_TABLE_DEPTH);
    end

    function automatic logic signed [15:0] sine_rom(input logic [23:0] ph);
        logic [SI-1:0] idx;
        idx = ph[23 -: SI];
        sine_rom = c_sine[idx];
    endfunction

    assign o_cfg_ready = (r_state == S_IDLE) && !o_out_valid;
    assign o_in_ready  = (r_state == S_IDLE) && !(i_cfg_valid && o_cfg_ready);

    // tap read position and ring words
    logic signed [17:0] t_delay;
    logic [PW-1:0] t_pos;
    logic [DI-1:0] t_i0, t_i1;
    logic signed [16:0] t_r0, t_r1;
    always_comb begin
        case (r_tap)
            2'd0:    t_delay = 18'(r_bh) + 18'(r_modh);
            2'd1:    t_delay = 18'(r_bd) + 18'(r_modd);
            2'd2:    t_delay = 18'(r_bh) - 18'(r_modh);
            default: t_delay = 18'(r_bd) - 18'(r_modd);
        endcase
        t_pos = PW'({r_wslot, 12'd0}) - PW'(t_delay);
        t_i0  = t_pos[PW-1:12];
        t_i1  = t_i0 + 1'b1;
        t_r0  = r_rvalid[t_i0] ? 17'(r_ring[t_i0]) : '0;
        t_r1  = r_rvalid[t_i1] ? 17'(r_ring[t_i1]) : '0;
    end

    logic signed [63:0] n_step;
    always_comb begin
        n_step  = rshr(m_p64, 24);
    end

    // issue a product whenever the sequencer moves on to a new one
    always_comb begin
        case (r_state)
            S_IDLE:  n_start = i_in_valid && o_in_ready;
            S_GH, S_GD, S_PH, S_PD, S_LP, S_SP, S_MODH, S_CH, S_CD, S_DOP:
                     n_start = m_done;
            S_TAP:   n_start = 1'b1;
            S_TAPW:  n_start = m_done && (r_tap == 2'd3);
            S_DOPW:  n_start = m_done && (r_tap == 2'd0);
            default: n_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_out_valid <= 1'b0;
            r_speed  <= 1'b0;
            r_spread <= 9'd192;
            r_pscale <= 16'd380;
            r_hrate  <= '0;
            r_drate  <= '0;
            r_hph    <= '0;
            r_dph    <= '0;
            r_lp     <= '0;
            r_wslot  <= '0;
            r_rvalid <= '0;
            r_tap    <= '0;
            r_sub    <= 1'b0;
            r_pend   <= '0;
            m_start  <= 1'b0;
        end else begin
            m_start <= n_start;
            // set on load from the hold state, drop once the pair is taken
            o_out_valid <= (r_state == S_HOLD) || (o_out_valid && !i_out_ready);
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_SPEED:  r_speed  <= i_cfg_data[0];
                    REG_SPREAD: r_spread <= i_cfg_data[8:0];
                    REG_PSCALE: r_pscale <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_x     <= 17'(i_sample_in);
                        m_a     <= MW'($signed({1'b0, r_speed ? HORN_FAST : HORN_SLOW})
                                       - $signed({1'b0, r_hrate}));
                        m_b     <= MW'({1'b0, HORN_GLIDE_K});
                        r_state <= S_GH;
                    end
                end
                S_GH, S_GD: begin
                    if (m_done) begin
                        if (r_state == S_GH) begin
                            r_hrate <= 16'(64'(r_hrate) + ((n_step == 0 && m_a != 0) ?
                                (m_a > 0 ? 64'sd1 : -64'sd1) : n_step));
                            m_a <= MW'($signed({1'b0, r_speed ? DRUM_FAST : DRUM_SLOW})
                                   - $signed({1'b0, r_drate}));
                            m_b <= MW'({1'b0, DRUM_GLIDE_K});
                            r_state <= S_GD;
                        end else begin
                            r_drate <= 16'(64'(r_drate) + ((n_step == 0 && m_a != 0) ?
                                (m_a > 0 ? 64'sd1 : -64'sd1) : n_step));
                            m_a <= MW'({1'b0, r_hrate});
                            m_b <= MW'({1'b0, r_pscale});
                            r_state <= S_PH;
                        end
                    end
                end
                S_PH: begin
                    if (m_done) begin
                        r_hph <= r_hph + 24'((m_p64 + 64'sd2048) >>> 12);
                        m_a <= MW'({1'b0, r_drate});
                        m_b <= MW'({1'b0, r_pscale});
                        r_state <= S_PD;
                    end
                end
                S_PD: begin
                    if (m_done) begin
                        r_dph <= r_dph + 24'((m_p64 + 64'sd2048) >>> 12);
                        m_a <= MW'(r_x - r_lp);
                        m_b <= MW'({1'b0, LP_COEF});
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    if (m_done) begin
                        r_lp   <= r_lp + 17'(rshr(m_p64, 16));
                        r_high <= r_x - (r_lp + 17'(rshr(m_p64, 16)));
                        r_ring[r_wslot]   <= r_x[15:0];
                        r_rvalid[r_wslot] <= 1'b1;
                        r_wslot <= r_wslot + 1'b1;
                        r_pend  <= '0;
                        m_a <= MW'(r_spread > 9'd256 ? 9'd256 : r_spread);
                        m_b <= MW'(24'd3277);
                        r_state <= S_SP;
                        r_sh <= sine_rom(r_hph);
                        r_sd <= sine_rom(r_dph);
                    end
                end
                S_SP: begin
                    // the clamped spread stays in m_a for all four products
                    if (m_done) begin
                        r_pend <= r_pend + 1'b1;
                        case (r_pend)
                            3'd0: begin
                                r_bh <= 16'(64'sd7373 + rshr(m_p64, 8));
                                m_b <= MW'(24'd3686);
                            end
                            3'd1: begin
                                r_bd <= 16'(64'sd13926 + rshr(m_p64, 8));
                                m_b <= MW'(24'd4506);
                            end
                            3'd2: begin
                                r_dh <= 16'(64'sd5734 + rshr(m_p64, 8));
                                m_b <= MW'(24'd2867);
                            end
                            default: begin
                                r_dd <= 16'(64'sd3277 + rshr(m_p64, 8));
                                m_a <= MW'({1'b0, r_dh});
                                m_b <= MW'(r_sh);
                                r_state <= S_MODH;
                            end
                        endcase
                    end
                end
                S_MODH: begin
                    if (m_done) begin
                        r_modh <= 17'(rshr(m_p64, 15));
                        m_a <= MW'({1'b0, r_dd});
                        m_b <= MW'(r_sd);
                        r_state <= S_MODD;
                    end
                end
                S_MODD: begin
                    if (m_done) begin
                        r_modd <= 17'(rshr(m_p64, 15));
                        r_tap  <= '0;
                        r_state <= S_TAP;
                    end
                end
                S_TAP: begin
                    m_a <= MW'(t_r1 - t_r0);
                    m_b <= MW'({1'b0, t_pos[11:0]});
                    r_tapv[r_tap] <= 18'(t_r0);
                    r_state <= S_TAPW;
                end
                S_TAPW: begin
                    if (m_done) begin
                        r_tapv[r_tap] <= r_tapv[r_tap] + 18'(rshr(m_p64, 12));
                        r_tap <= r_tap + 1'b1;
                        if (r_tap == 2'd3) begin
                            m_a <= MW'(sine_rom(r_hph + 24'h400000));
                            m_b <= MW'({1'b0, GAIN_HORN});
                            r_state <= S_CH;
                        end else begin
                            r_state <= S_TAP;
                        end
                    end
                end
                S_CH: begin
                    if (m_done) begin
                        r_gl <= 18'({2'b0, GAIN_BASE}) + 18'(rshr(m_p64, 15));
                        r_gr <= 18'({2'b0, GAIN_BASE}) - 18'(rshr(m_p64, 15));
                        m_a <= MW'(sine_rom(r_dph + 24'h400000));
                        m_b <= MW'({1'b0, GAIN_DRUM});
                        r_state <= S_CD;
                    end
                end
                S_CD: begin
                    if (m_done) begin
                        r_gl <= r_gl + 18'(rshr(m_p64, 15));
                        r_gr <= r_gr - 18'(rshr(m_p64, 15));
                        r_tap <= '0;
                        r_sub <= 1'b0;
                        m_a <= MW'(r_tapv[0]);
                        m_b <= MW'(r_high);
                        r_state <= S_DOP;
                    end
                end
                S_DOP: begin
                    // tap products: horn*high then drum*low, per side
                    if (m_done) begin
                        if (!r_sub) begin
                            r_dacc <= m_p;
                            m_a <= MW'(r_tapv[r_tap + 2'd1]);
                            m_b <= MW'(r_lp);
                            r_sub <= 1'b1;
                        end else begin
                            r_sub <= 1'b0;
                            m_a <= MW'(rshr(64'(r_dacc) + m_p64, 15));
                            m_b <= (r_tap == 2'd0) ? MW'(r_gl) : MW'(r_gr);
                            r_state <= S_DOPW;
                        end
                    end
                end
                S_DOPW: begin
                    if (m_done) begin
                        if (r_tap == 2'd0) begin
                            r_dopl <= 18'(rshr(m_p64, 15) > 64'sd32767 ? 64'sd32767 :
                                rshr(m_p64, 15) < -64'sd32768 ? -64'sd32768 :
                                rshr(m_p64, 15));
                            r_tap <= 2'd2;
                            m_a <= MW'(r_tapv[2]);
                            m_b <= MW'(r_high);
                            r_state <= S_DOP;
                        end else begin
                            r_dopl <= r_dopl;
                            r_sh   <= 16'(rshr(m_p64, 15) > 64'sd32767 ? 64'sd32767 :
                                rshr(m_p64, 15) < -64'sd32768 ? -64'sd32768 :
                                rshr(m_p64, 15));
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    // hold the finished pair until the output register frees
                    if (!o_out_valid || i_out_ready) begin
                        o_left_out  <= r_dopl[15:0];
                        o_right_out <= r_sh;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
